>>> sv/apsd_pkg.sv
package apsd_pkg;

  // fixed field and register widths
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned ROOT_STEPS = 16;

  localparam logic [MAG_W-1:0] GRAVITY_CENTI = 17'd980;
  localparam logic [7:0]       RUN_MAX       = 8'd255;
  localparam logic [6:0]       MIN_WINDOW    = 7'd2;

  // register reset values
  localparam logic [6:0]  RST_WINDOW_LENGTH  = 7'd50;
  localparam logic [15:0] RST_P2P_THRESHOLD  = 16'd200;
  localparam logic [15:0] RST_DEV_THRESHOLD  = 16'd100;
  localparam logic [15:0] RST_MAX_MOTION_MS  = 16'd200;
  localparam logic [15:0] RST_MIN_MOTION_MS  = 16'd20;
  localparam logic [7:0]  RST_SIGNALS_NEEDED = 8'd4;
  localparam logic [15:0] RST_MIN_STEP_GAP   = 16'd1000;
  localparam logic [15:0] RST_WALK_TIMEOUT   = 16'd4000;

  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH,
    REG_P2P_THRESHOLD,
    REG_DEV_THRESHOLD,
    REG_MAX_MOTION_MS,
    REG_MIN_MOTION_MS,
    REG_SIGNALS_NEEDED,
    REG_MIN_STEP_GAP,
    REG_WALK_TIMEOUT
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic        step_detected;
    logic [31:0] step_total;
    logic        walking;
    logic        window_full;
  } result_t;

  typedef struct packed {
    logic [6:0]  window_length;
    logic [15:0] peak_to_peak_threshold;
    logic [15:0] peak_deviation_threshold;
    logic [15:0] max_motion_ms;
    logic [15:0] min_motion_ms;
    logic [7:0]  signals_needed;
    logic [15:0] min_step_gap_ms;
    logic [15:0] walking_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0] crest;
    logic [MAG_W-1:0] trough;
  } ring_stat_t;

  typedef struct packed {
    logic        step_detected;
    logic [31:0] step_total;
    logic        walking;
  } track_stat_t;

  typedef enum logic [1:0] {
    MAG_IDLE,
    MAG_SQUARE,
    MAG_ROOT,
    MAG_DONE
  } mag_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } seq_state_t;

endpackage

>>> sv/apsd_regs.sv
module apsd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output apsd_pkg::cfg_t               cfg
);

  apsd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = apsd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length            <= apsd_pkg::RST_WINDOW_LENGTH;
      cfg.peak_to_peak_threshold   <= apsd_pkg::RST_P2P_THRESHOLD;
      cfg.peak_deviation_threshold <= apsd_pkg::RST_DEV_THRESHOLD;
      cfg.max_motion_ms            <= apsd_pkg::RST_MAX_MOTION_MS;
      cfg.min_motion_ms            <= apsd_pkg::RST_MIN_MOTION_MS;
      cfg.signals_needed           <= apsd_pkg::RST_SIGNALS_NEEDED;
      cfg.min_step_gap_ms          <= apsd_pkg::RST_MIN_STEP_GAP;
      cfg.walking_timeout_ms       <= apsd_pkg::RST_WALK_TIMEOUT;
    end else if (wr_en) begin
      case (idx)
        apsd_pkg::REG_WINDOW_LENGTH:  cfg.window_length            <= pwdata[6:0];
        apsd_pkg::REG_P2P_THRESHOLD:  cfg.peak_to_peak_threshold   <= pwdata[15:0];
        apsd_pkg::REG_DEV_THRESHOLD:  cfg.peak_deviation_threshold <= pwdata[15:0];
        apsd_pkg::REG_MAX_MOTION_MS:  cfg.max_motion_ms            <= pwdata[15:0];
        apsd_pkg::REG_MIN_MOTION_MS:  cfg.min_motion_ms            <= pwdata[15:0];
        apsd_pkg::REG_SIGNALS_NEEDED: cfg.signals_needed           <= pwdata[7:0];
        apsd_pkg::REG_MIN_STEP_GAP:   cfg.min_step_gap_ms          <= pwdata[15:0];
        apsd_pkg::REG_WALK_TIMEOUT:   cfg.walking_timeout_ms       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      apsd_pkg::REG_WINDOW_LENGTH:  prdata = {25'd0, cfg.window_length};
      apsd_pkg::REG_P2P_THRESHOLD:  prdata = {16'd0, cfg.peak_to_peak_threshold};
      apsd_pkg::REG_DEV_THRESHOLD:  prdata = {16'd0, cfg.peak_deviation_threshold};
      apsd_pkg::REG_MAX_MOTION_MS:  prdata = {16'd0, cfg.max_motion_ms};
      apsd_pkg::REG_MIN_MOTION_MS:  prdata = {16'd0, cfg.min_motion_ms};
      apsd_pkg::REG_SIGNALS_NEEDED: prdata = {24'd0, cfg.signals_needed};
      apsd_pkg::REG_MIN_STEP_GAP:   prdata = {16'd0, cfg.min_step_gap_ms};
      apsd_pkg::REG_WALK_TIMEOUT:   prdata = {16'd0, cfg.walking_timeout_ms};
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> sv/apsd_mag.sv
module apsd_mag (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [15:0]         accel_x,
  input  logic signed [15:0]         accel_y,
  input  logic signed [15:0]         accel_z,
  output logic                       done,
  output logic [apsd_pkg::MAG_W-1:0] mag
);

  localparam logic [1:0]  LastSquare = 2'd2;
  localparam logic [3:0]  LastRoot   = 4'(apsd_pkg::ROOT_STEPS - 1);
  localparam logic [31:0] RootTopBit = 32'h4000_0000;

  apsd_pkg::mag_state_t state, state_next;
  logic [1:0]           sq_idx;
  logic [3:0]           root_idx;
  logic [31:0]          acc;
  logic [31:0]          res;
  logic [31:0]          bitv;
  logic signed [15:0]   opnd;
  logic signed [31:0]   prod;
  logic [31:0]          trial;

  // one multiplier for the squares, one adder and compare for the root
  always_comb begin
    case (sq_idx)
      2'd0:    opnd = accel_x;
      2'd1:    opnd = accel_y;
      default: opnd = accel_z;
    endcase
  end

  assign prod  = opnd * opnd;
  assign trial = res + bitv;
  assign mag   = res[apsd_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apsd_pkg::MAG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      apsd_pkg::MAG_IDLE: begin
        if (start) state_next = apsd_pkg::MAG_SQUARE;
      end
      apsd_pkg::MAG_SQUARE: begin
        if (sq_idx == LastSquare) state_next = apsd_pkg::MAG_ROOT;
      end
      apsd_pkg::MAG_ROOT: begin
        if (root_idx == LastRoot) state_next = apsd_pkg::MAG_DONE;
      end
      apsd_pkg::MAG_DONE: begin
        done       = 1'b1;
        state_next = apsd_pkg::MAG_IDLE;
      end
      default: state_next = apsd_pkg::MAG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      apsd_pkg::MAG_IDLE: begin
        acc    <= '0;
        sq_idx <= '0;
      end
      apsd_pkg::MAG_SQUARE: begin
        acc    <= acc + $unsigned(prod);
        sq_idx <= sq_idx + 2'd1;
        if (sq_idx == LastSquare) begin
          res      <= '0;
          bitv     <= RootTopBit;
          root_idx <= '0;
        end
      end
      apsd_pkg::MAG_ROOT: begin
        // one result bit per cycle
        if (acc >= trial) begin
          acc <= acc - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv     <= bitv >> 2;
        root_idx <= root_idx + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/apsd_ring.sv
module apsd_ring #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [6:0]                 window_length,
  input  logic                       store,
  input  logic [apsd_pkg::MAG_W-1:0] store_data,
  input  logic                       scan_start,
  output logic                       wrapped,
  output logic                       scan_done,
  output apsd_pkg::ring_stat_t       stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [apsd_pkg::MAG_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [AW-1:0]              pos;
  logic [CW-1:0]              len;
  logic [CW-1:0]              pos_inc;
  logic [CW-1:0]              scan_cnt;
  logic                       scanning;
  logic                       issue_last;
  logic                       data_pend;
  logic                       data_last;
  logic                       first;
  logic [apsd_pkg::MAG_W-1:0] rdata_q;
  logic                       rvld_q;
  logic [apsd_pkg::MAG_W-1:0] rdata;

  // window length clamped to MIN_WINDOW..DEPTH
  always_comb begin
    if (32'(window_length) > 32'(DEPTH)) begin
      len = CW'(DEPTH);
    end else if (window_length < apsd_pkg::MIN_WINDOW) begin
      len = CW'(apsd_pkg::MIN_WINDOW);
    end else begin
      len = CW'(window_length);
    end
  end

  assign pos_inc    = CW'(pos) + CW'(1);
  assign issue_last = scanning && (scan_cnt == len - CW'(1));
  assign rdata      = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk) begin
    if (store) mem[pos] <= store_data;
    rdata_q <= mem[scan_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      pos       <= '0;
      wrapped   <= 1'b0;
      scanning  <= 1'b0;
      data_pend <= 1'b0;
      data_last <= 1'b0;
      scan_done <= 1'b0;
      scan_cnt  <= '0;
      rvld_q    <= 1'b0;
    end else begin
      rvld_q    <= vld[scan_cnt[AW-1:0]];
      data_pend <= scanning;
      data_last <= issue_last;
      scan_done <= data_pend && data_last;
      if (store) begin
        vld[pos] <= 1'b1;
        if (pos_inc >= len) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos_inc[AW-1:0];
        end
      end
      if (scan_start) begin
        scanning <= 1'b1;
        scan_cnt <= '0;
      end else if (scanning) begin
        scan_cnt <= scan_cnt + CW'(1);
        if (issue_last) scanning <= 1'b0;
      end
    end
  end

  // running crest and trough, one entry a cycle
  always_ff @(posedge clk) begin
    if (scan_start) begin
      first <= 1'b1;
    end else if (data_pend) begin
      first <= 1'b0;
      if (first || rdata > stat.crest)  stat.crest  <= rdata;
      if (first || rdata < stat.trough) stat.trough <= rdata;
    end
  end

endmodule

>>> sv/apsd_track.sv
module apsd_track (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  apsd_pkg::cfg_t        cfg,
  input  apsd_pkg::ring_stat_t  stat,
  input  logic [31:0]           now,
  output apsd_pkg::track_stat_t track
);

  logic [31:0]                last_step_stamp, last_step_stamp_next;
  logic                       motion_active, motion_active_next;
  logic [31:0]                motion_start_stamp, motion_start_stamp_next;
  logic [7:0]                 signal_run, signal_run_next;
  logic [31:0]                steps_counted, steps_counted_next;
  logic [31:0]                last_seen_stamp, last_seen_stamp_next;
  logic                       walking_flag, walking_flag_next;
  logic                       step_flag;
  logic                       added;
  logic [apsd_pkg::MAG_W-1:0] swing;
  logic [apsd_pkg::MAG_W-1:0] dev;
  logic                       sig;
  logic [31:0]                since_step;
  logic [31:0]                dur;
  logic [31:0]                idle_time;
  logic [7:0]                 run_inc;
  logic                       confirm;

  assign swing = stat.crest - stat.trough;
  assign dev   = (stat.crest >= apsd_pkg::GRAVITY_CENTI) ?
                 stat.crest - apsd_pkg::GRAVITY_CENTI :
                 apsd_pkg::GRAVITY_CENTI - stat.crest;
  assign sig   = (swing > {1'b0, cfg.peak_to_peak_threshold}) &&
                 (dev > {1'b0, cfg.peak_deviation_threshold});

  assign since_step = now - last_step_stamp;
  assign dur        = now - motion_start_stamp;
  assign idle_time  = now - last_seen_stamp;
  assign run_inc    = (signal_run < apsd_pkg::RUN_MAX) ? signal_run + 8'd1 : signal_run;
  assign confirm    = (run_inc >= cfg.signals_needed) &&
                      (dur >= 32'(cfg.min_motion_ms)) && (dur <= 32'(cfg.max_motion_ms));

  always_comb begin
    last_step_stamp_next    = last_step_stamp;
    motion_active_next      = motion_active;
    motion_start_stamp_next = motion_start_stamp;
    signal_run_next         = signal_run;
    steps_counted_next      = steps_counted;
    last_seen_stamp_next    = last_seen_stamp;
    walking_flag_next       = walking_flag;
    added                   = 1'b0;
    if (sig && !motion_active && since_step >= 32'(cfg.min_step_gap_ms)) begin
      motion_active_next      = 1'b1;
      motion_start_stamp_next = now;
      signal_run_next         = 8'd1;
    end else if (sig && motion_active) begin
      signal_run_next = run_inc;
      if (confirm) begin
        steps_counted_next   = steps_counted + 32'd1;
        last_step_stamp_next = now;
        motion_active_next   = 1'b0;
        signal_run_next      = '0;
        added                = 1'b1;
      end else if (dur > 32'(cfg.max_motion_ms)) begin
        motion_active_next = 1'b0;
        signal_run_next    = '0;
      end
    end else if (!sig && motion_active) begin
      motion_active_next = 1'b0;
      signal_run_next    = '0;
    end
    if (added) begin
      last_seen_stamp_next = now;
      walking_flag_next    = 1'b1;
    end else if (idle_time > 32'(cfg.walking_timeout_ms)) begin
      walking_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_step_stamp    <= '0;
      motion_active      <= 1'b0;
      motion_start_stamp <= '0;
      signal_run         <= '0;
      steps_counted      <= '0;
      last_seen_stamp    <= '0;
      walking_flag       <= 1'b0;
      step_flag          <= 1'b0;
    end else if (update) begin
      last_step_stamp    <= last_step_stamp_next;
      motion_active      <= motion_active_next;
      motion_start_stamp <= motion_start_stamp_next;
      signal_run         <= signal_run_next;
      steps_counted      <= steps_counted_next;
      last_seen_stamp    <= last_seen_stamp_next;
      walking_flag       <= walking_flag_next;
      step_flag          <= added;
    end
  end

  assign track.step_detected = step_flag;
  assign track.step_total    = steps_counted;
  assign track.walking       = walking_flag;

endmodule

>>> sv/accel_peak_step_detector_top.sv
// a result is offered after its sample's magnitude is stored and, once the ring has wrapped,
// after the window scan (window clamped to 2..WINDOW_DEPTH) and the tracker update
// throughput: one sample at a time; the next sample can be taken the cycle after the result is
// loaded; the pace is set by the shared square-and-root unit and the one-port window scan
// reset: synchronous, active high; ring valid bits clear at once, no clearing pass
module accel_peak_step_detector_top #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample channel
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  apsd_pkg::sample_t            sample,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output apsd_pkg::result_t            result,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  apsd_pkg::seq_state_t       state, state_next;
  apsd_pkg::cfg_t             cfg;
  apsd_pkg::sample_t          held;
  apsd_pkg::ring_stat_t       stat;
  apsd_pkg::track_stat_t      track;
  logic                       mag_start;
  logic                       mag_done;
  logic [apsd_pkg::MAG_W-1:0] mag;
  logic                       scan_start;
  logic                       scan_done;
  logic                       wrapped;
  logic                       track_upd;
  logic                       load;

  // configuration registers
  apsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiply and root unit, reads the held sample
  apsd_mag u_mag (
    .clk     (clk),
    .rst     (rst),
    .start   (mag_start),
    .accel_x (held.accel_x),
    .accel_y (held.accel_y),
    .accel_z (held.accel_z),
    .done    (mag_done),
    .mag     (mag)
  );

  // magnitude ring, written on the root result, scanned for crest and trough
  apsd_ring #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk           (clk),
    .rst           (rst),
    .window_length (cfg.window_length),
    .store         (mag_done),
    .store_data    (mag),
    .scan_start    (scan_start),
    .wrapped       (wrapped),
    .scan_done     (scan_done),
    .stat          (stat)
  );

  // motion tracker and walking flag, stepped once per window scan
  apsd_track u_track (
    .clk    (clk),
    .rst    (rst),
    .update (track_upd),
    .cfg    (cfg),
    .stat   (stat),
    .now    (held.time_ms),
    .track  (track)
  );

  // only the idle state takes a new beat
  assign sample_stall = (state != apsd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) held <= sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: root, store, optional scan and track, then emit
  always_comb begin
    state_next = state;
    mag_start  = 1'b0;
    scan_start = 1'b0;
    track_upd  = 1'b0;
    load       = 1'b0;
    case (state)
      apsd_pkg::S_IDLE: begin
        if (sample_valid) begin
          mag_start  = 1'b1;
          state_next = apsd_pkg::S_MAG;
        end
      end
      apsd_pkg::S_MAG: begin
        // the ring stores the magnitude on the done cycle
        if (mag_done) state_next = apsd_pkg::S_CHECK;
      end
      apsd_pkg::S_CHECK: begin
        // before the first wrap the sample is only stored
        if (wrapped) begin
          scan_start = 1'b1;
          state_next = apsd_pkg::S_SCAN;
        end else begin
          state_next = apsd_pkg::S_EMIT;
        end
      end
      apsd_pkg::S_SCAN: begin
        if (scan_done) begin
          track_upd  = 1'b1;
          state_next = apsd_pkg::S_EMIT;
        end
      end
      apsd_pkg::S_EMIT: begin
        // wait for the output register to drain
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = apsd_pkg::S_IDLE;
        end
      end
      default: state_next = apsd_pkg::S_IDLE;
    endcase
  end

  // output register parts the result side from the sample side
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.step_detected <= track.step_detected && wrapped;
      result.step_total    <= track.step_total;
      result.walking       <= track.walking;
      result.window_full   <= wrapped;
    end
  end

`ifndef SYNTH
  a_step_implies_walk: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.step_detected || (result.walking && result.window_full)))
    else $error("step reported without walking flag or full window");

  a_mag_done_in_seq: assert property (@(posedge clk) disable iff (rst)
    mag_done |-> (state == apsd_pkg::S_MAG))
    else $error("root unit finished outside its sequencer state");

  a_scan_done_in_seq: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == apsd_pkg::S_SCAN))
    else $error("window scan finished outside its sequencer state");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == apsd_pkg::S_EMIT && (!result_valid || !result_stall))
      |=> (result_valid && state == apsd_pkg::S_IDLE))
    else $error("result not loaded on a free output register");
`endif

endmodule
